// ----- hw/rtl/mch_pkg.sv -----
// ----------------------------------------------------------------------------
// mch_pkg
// Shared types and constants for the masked cumulative histogram.
// ----------------------------------------------------------------------------
package mch_pkg;

   localparam int MCH_HIST_BINS_DEF  = 1024;
   localparam int MCH_COUNT_BITS_DEF = 32;

   localparam int SAMPLE_BITS    = 16;
   localparam int SCALE_BITS     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int PROD_BITS      = SAMPLE_BITS + SCALE_BITS;
   localparam int BIN_INDEX_BITS = 10;
   localparam int FRAC_OUT_BITS  = FRAC_BITS + 1;
   localparam int STEP_BITS      = $clog2(FRAC_BITS + 1);
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [FRAC_OUT_BITS-1:0] ONE_Q16 = FRAC_OUT_BITS'(1) << FRAC_BITS;

   // register reset values
   localparam logic [SAMPLE_BITS-1:0] VALUE_MIN_RST = '0;
   localparam logic [SCALE_BITS-1:0]  BIN_SCALE_RST = SCALE_BITS'(1023);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VALUE_MIN = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIN_SCALE = 1'b1;

   // request kinds
   localparam logic REQ_ACCUM   = 1'b0;
   localparam logic REQ_READOUT = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [SAMPLE_BITS-1:0] sample_value;
      logic                   sample_missing;
   } mch_req_type;

   typedef struct packed {
      logic [BIN_INDEX_BITS-1:0] bin_index;
      logic [FRAC_OUT_BITS-1:0]  cum_fraction;
      logic                      last_bin;
      logic                      clipped_seen;
      logic                      no_valid;
   } mch_rsp_type;

endpackage

// ----- hw/rtl/mch_front.sv -----
// ----------------------------------------------------------------------------
// mch_front
// Accepts requests, drops nodata samples, computes and clamps the bin index
// over two stages and pushes the classified transaction into the queue.
// Also holds the configuration registers.
// ----------------------------------------------------------------------------
module mch_front import mch_pkg::*; #(
   parameter int HIST_BINS = MCH_HIST_BINS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mch_req_type                   req_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          clear_busy,
   output logic                          q_valid,
   input  logic                          q_ready,
   output logic [$clog2(HIST_BINS)+1:0]  q_data
);

   localparam int BIN_BITS = $clog2(HIST_BINS);
   localparam logic [SCALE_BITS-1:0] LAST_IDX = SCALE_BITS'(HIST_BINS - 1);

   logic [SAMPLE_BITS-1:0] value_min_ff, value_min_in;
   logic [SCALE_BITS-1:0]  bin_scale_ff, bin_scale_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_kind_ff,  s1_kind_in;
   logic                   s1_below_ff, s1_below_in;
   logic [SAMPLE_BITS-1:0] s1_diff_ff,  s1_diff_in;

   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_kind_ff,  s2_kind_in;
   logic                   s2_below_ff, s2_below_in;
   logic [PROD_BITS-1:0]   s2_prod_ff,  s2_prod_in;

   logic                   s1_free, s2_free, req_take, csr_take;
   logic [SAMPLE_BITS:0]   diff_wide;
   logic [SCALE_BITS-1:0]  idx_hi;
   logic                   over;
   logic [BIN_BITS-1:0]    q_index;
   logic                   q_clip;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   assign s2_free   = !s2_valid_ff || q_ready;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free && !clear_busy;
   // a nodata sample changes nothing, so it goes no further
   assign req_take  = req_valid && req_ready &&
                      !(req_data.req_type == REQ_ACCUM && req_data.sample_missing);

   assign diff_wide = {1'b0, req_data.sample_value} - {1'b0, value_min_ff};
   assign idx_hi    = s2_prod_ff[PROD_BITS-1:FRAC_BITS];
   assign over      = idx_hi > LAST_IDX;

   always_comb begin
      value_min_in = value_min_ff;
      bin_scale_in = bin_scale_ff;
      if (csr_take) begin
         case (csr_index)
            CSR_VALUE_MIN: value_min_in = csr_wdata[SAMPLE_BITS-1:0];
            CSR_BIN_SCALE: bin_scale_in = csr_wdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end

      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_below_in = s1_below_ff;
      s1_diff_in  = s1_diff_ff;
      if (s1_free) begin
         s1_valid_in = req_take;
         s1_kind_in  = req_data.req_type;
         s1_below_in = diff_wide[SAMPLE_BITS];
         s1_diff_in  = diff_wide[SAMPLE_BITS-1:0];
      end

      s2_valid_in = s2_valid_ff;
      s2_kind_in  = s2_kind_ff;
      s2_below_in = s2_below_ff;
      s2_prod_in  = s2_prod_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
         s2_kind_in  = s1_kind_ff;
         s2_below_in = s1_below_ff;
         s2_prod_in  = PROD_BITS'(s1_diff_ff) * PROD_BITS'(bin_scale_ff);
      end
   end

   always_comb begin
      q_index = idx_hi[BIN_BITS-1:0];
      q_clip  = 1'b0;
      if (s2_kind_ff == REQ_READOUT) begin
         q_index = '0;
      end else if (s2_below_ff) begin
         q_index = '0;
         q_clip  = 1'b1;
      end else if (over) begin
         q_index = LAST_IDX[BIN_BITS-1:0];
         q_clip  = 1'b1;
      end
   end

   assign q_valid = s2_valid_ff;
   assign q_data  = {s2_kind_ff, q_clip, q_index};

   always_ff @(posedge clock) begin
      if (reset) begin
         value_min_ff <= VALUE_MIN_RST;
         bin_scale_ff <= BIN_SCALE_RST;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         value_min_ff <= value_min_in;
         bin_scale_ff <= bin_scale_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
      end
      s1_kind_ff  <= s1_kind_in;
      s1_below_ff <= s1_below_in;
      s1_diff_ff  <= s1_diff_in;
      s2_kind_ff  <= s2_kind_in;
      s2_below_ff <= s2_below_in;
      s2_prod_ff  <= s2_prod_in;
   end

endmodule

// ----- hw/rtl/mch_queue.sv -----
// ----------------------------------------------------------------------------
// mch_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module mch_queue import mch_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/mch_div.sv -----
// ----------------------------------------------------------------------------
// mch_div
// Restoring divider for the Q16 cumulative fraction, one quotient bit a cycle.
// A sum not below the total gives one (65536) at once.
// ----------------------------------------------------------------------------
module mch_div import mch_pkg::*; #(
   parameter int COUNT_BITS = MCH_COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [COUNT_BITS-1:0]    dividend,
   input  logic [COUNT_BITS-1:0]    divisor,
   output logic                     done,
   output logic [FRAC_OUT_BITS-1:0] quotient
);

   localparam logic [STEP_BITS-1:0] STEPS = STEP_BITS'(FRAC_BITS);

   logic                     busy_ff, busy_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [COUNT_BITS-1:0]    rem_ff,  rem_in;
   logic [COUNT_BITS-1:0]    dvs_ff,  dvs_in;
   logic [FRAC_OUT_BITS-1:0] quo_ff,  quo_in;
   logic [COUNT_BITS:0]      shifted, diff;
   logic                     ge;

   assign shifted  = {rem_ff, 1'b0};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign ge       = shifted >= {1'b0, dvs_ff};
   assign done     = busy_ff && (step_ff == '0);
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         dvs_in  = divisor;
         rem_in  = dividend;
         if (dividend >= divisor) begin
            // fraction saturates at one
            quo_in  = ONE_Q16;
            step_in = '0;
         end else begin
            quo_in  = '0;
            step_in = STEPS;
         end
      end else if (busy_ff) begin
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
            rem_in  = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            quo_in  = {quo_ff[FRAC_OUT_BITS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

endmodule

// ----- hw/rtl/mch_back.sv -----
// ----------------------------------------------------------------------------
// mch_back
// Executes queued transactions against the bin memory: read-modify-write for
// samples, read-and-clear plus a normalizing divide when any sample is valid
// for readouts. Clears the memory after reset and holds the result register.
// ----------------------------------------------------------------------------
module mch_back import mch_pkg::*; #(
   parameter int HIST_BINS  = MCH_HIST_BINS_DEF,
   parameter int COUNT_BITS = MCH_COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  logic [$clog2(HIST_BINS)+1:0]  q_data,
   output logic                          clear_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mch_rsp_type                   rsp_data,
   output logic                          div_start,
   output logic [COUNT_BITS-1:0]         div_dividend,
   output logic [COUNT_BITS-1:0]         div_divisor,
   input  logic                          div_done,
   input  logic [FRAC_OUT_BITS-1:0]      div_quotient
);

   localparam int BIN_BITS = $clog2(HIST_BINS);
   localparam logic [BIN_BITS-1:0] LAST_IDX = BIN_BITS'(HIST_BINS - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [COUNT_BITS-1:0] bin_mem [HIST_BINS];
   logic [COUNT_BITS-1:0] rd_data_ff;

   logic [2:0]            state_ff,       state_in;
   logic [BIN_BITS-1:0]   clr_addr_ff,    clr_addr_in;
   logic                  op_kind_ff,     op_kind_in;
   logic                  op_clip_ff,     op_clip_in;
   logic [BIN_BITS-1:0]   op_index_ff,    op_index_in;
   logic [BIN_BITS-1:0]   read_ptr_ff,    read_ptr_in;
   logic [COUNT_BITS-1:0] valid_total_ff, valid_total_in;
   logic [COUNT_BITS-1:0] running_sum_ff, running_sum_in;
   logic                  clip_ff,        clip_in;
   mch_rsp_type           pend_ff,        pend_in;
   logic                  rsp_valid_ff,   rsp_valid_in;
   mch_rsp_type           rsp_data_ff,    rsp_data_in;

   logic                  mem_we, mem_re;
   logic [BIN_BITS-1:0]   mem_waddr, mem_raddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   logic                  e_kind, e_clip;
   logic [BIN_BITS-1:0]   e_index;
   logic [COUNT_BITS-1:0] bin_inc, total_inc, sum_new;
   logic [COUNT_BITS:0]   sum_wide;
   logic [BIN_BITS+BIN_INDEX_BITS-1:0] index_wide;
   logic                  is_last, no_valid;

   assign {e_kind, e_clip, e_index} = q_data;

   assign bin_inc    = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
   assign total_inc  = (valid_total_ff == '1) ? valid_total_ff : valid_total_ff + 1'b1;
   assign sum_wide   = {1'b0, running_sum_ff} + {1'b0, rd_data_ff};
   assign sum_new    = sum_wide[COUNT_BITS] ? '1 : sum_wide[COUNT_BITS-1:0];
   assign index_wide = {{BIN_INDEX_BITS{1'b0}}, op_index_ff};
   assign is_last    = op_index_ff == LAST_IDX;
   assign no_valid   = valid_total_ff == '0;

   assign q_ready      = state_ff == ST_IDLE;
   assign clear_busy   = state_ff == ST_CLEAR;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign div_dividend = sum_new;
   assign div_divisor  = valid_total_ff;

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      op_kind_in     = op_kind_ff;
      op_clip_in     = op_clip_ff;
      op_index_in    = op_index_ff;
      read_ptr_in    = read_ptr_ff;
      valid_total_in = valid_total_ff;
      running_sum_in = running_sum_ff;
      clip_in        = clip_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_waddr      = op_index_ff;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = e_index;
      div_start      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = BIN_BITS'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               mem_re      = 1'b1;
               mem_raddr   = (e_kind == REQ_READOUT) ? read_ptr_ff : e_index;
               op_kind_in  = e_kind;
               op_clip_in  = e_clip;
               op_index_in = mem_raddr;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            mem_we = 1'b1;
            if (op_kind_ff == REQ_ACCUM) begin
               mem_wdata      = bin_inc;
               valid_total_in = total_inc;
               clip_in        = clip_ff | op_clip_ff;
               state_in       = ST_IDLE;
            end else begin
               // readout clears the bin it reads
               mem_wdata            = '0;
               pend_in.bin_index    = index_wide[BIN_INDEX_BITS-1:0];
               pend_in.cum_fraction = '0;
               pend_in.last_bin     = is_last;
               pend_in.clipped_seen = clip_ff;
               pend_in.no_valid     = no_valid;
               running_sum_in       = sum_new;
               if (is_last) begin
                  read_ptr_in    = '0;
                  valid_total_in = '0;
                  running_sum_in = '0;
                  clip_in        = 1'b0;
               end else begin
                  read_ptr_in = BIN_BITS'(op_index_ff + 1'b1);
               end
               if (no_valid) begin
                  state_in = ST_RESP;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pend_in.cum_fraction = div_quotient;
               state_in             = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= bin_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         read_ptr_ff    <= '0;
         valid_total_ff <= '0;
         running_sum_ff <= '0;
         clip_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         read_ptr_ff    <= read_ptr_in;
         valid_total_ff <= valid_total_in;
         running_sum_ff <= running_sum_in;
         clip_ff        <= clip_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_kind_ff  <= op_kind_in;
      op_clip_ff  <= op_clip_in;
      op_index_ff <= op_index_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hw/rtl/masked_cumulative_histogram.sv -----
// ----------------------------------------------------------------------------
// masked_cumulative_histogram
// Histogram of masked pixel samples with normalized cumulative readout.
// ----------------------------------------------------------------------------
// After reset the block sweeps its bin memory to zero, one bin a cycle, and
// holds req_ready low meanwhile; configuration writes are taken throughout.
// Requests pass through a two-stage front (subtract, then multiply by bin_scale
// and clamp) into a four-entry queue, so the front keeps taking requests while
// the back is busy, until the queue is full. The back works on one transaction
// at a time over a single-port bin memory: a sample is read, then written back;
// nodata samples are dropped in the front and never reach the port; a readout
// reads and clears its bin, then runs the 16-step divider that forms the Q16
// fraction (skipped when there are no valid samples; no steps when the fraction
// is one). The back takes no new sample until the last one is written back.
// ----------------------------------------------------------------------------
module masked_cumulative_histogram import mch_pkg::*; #(
   parameter int HIST_BINS  = MCH_HIST_BINS_DEF,
   parameter int COUNT_BITS = MCH_COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mch_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mch_rsp_type               rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int BIN_BITS = $clog2(HIST_BINS);

   logic                     clear_busy;
   logic                     fq_valid, fq_ready, bq_valid, bq_ready;
   logic [BIN_BITS+1:0]      fq_data, bq_data;
   logic                     div_start, div_done;
   logic [COUNT_BITS-1:0]    div_dividend, div_divisor;
   logic [FRAC_OUT_BITS-1:0] div_quotient;

   mch_front #(
      .HIST_BINS (HIST_BINS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .clear_busy (clear_busy),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_data     (fq_data)
   );

   mch_queue #(
      .WIDTH (BIN_BITS + 2),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_data   (bq_data)
   );

   mch_back #(
      .HIST_BINS  (HIST_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (bq_valid),
      .q_ready      (bq_ready),
      .q_data       (bq_data),
      .clear_busy   (clear_busy),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   mch_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

// ----- hw/rtl/mch_checker.sv -----
// ----------------------------------------------------------------------------
// mch_checker
// Port-level checks for the masked cumulative histogram.
// ----------------------------------------------------------------------------
module mch_checker import mch_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input mch_rsp_type rsp_data
);

   // no result may survive a reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // bin memory sweep keeps requests out after reset
   a_req_blocked_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   a_empty_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_valid |-> rsp_data.cum_fraction == '0)
      else $error("non-zero fraction with no valid samples");

   a_fraction_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cum_fraction <= ONE_Q16)
      else $error("fraction above one");

endmodule

bind masked_cumulative_histogram mch_checker u_mch_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
